// ----- src/ufst_pkg.sv -----
// shared constants and types for the udp flow statistics table
`timescale 1ns / 1ps
package ufst_pkg;
   localparam int FLOW_SLOTS = 1024;
   localparam int IDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam int CNT_W = $clog2(FLOW_SLOTS + 1);
   localparam int KEY_W = 96;
   localparam int RATE_W = 30;
   localparam int STAT_W = 64 + 64 + 64 + RATE_W;
   localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'hC30B0E05;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [RATE_W-1:0] NS_PER_SEC = 30'd1000000000;

   typedef struct packed {
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [63:0] last_time;
      logic [RATE_W-1:0] rate;
   } stat_type;
endpackage

// ----- src/ufst_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module ufst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/ufst_div.sv -----
// bit-serial divider: one billion over a 64-bit interval
`timescale 1ns / 1ps
module ufst_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [63:0] divisor,
   output logic done,
   output logic [ufst_pkg::RATE_W-1:0] quotient
);
   import ufst_pkg::*;

   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [4:0] step_ff, step_in;
   logic [RATE_W:0] rem_ff, rem_in;
   logic [RATE_W-1:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [RATE_W:0] trial;

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      trial = {rem_ff[RATE_W-1:0], NS_PER_SEC[step_ff]};
      if (start) begin
         run_in = 1'b1;
         step_in = 5'(RATE_W - 1);
         rem_in = '0;
         quo_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         // remainder never exceeds the dividend, so 31 bits hold it
         if ({33'd0, trial} >= dvs_ff) begin
            rem_in = trial - dvs_ff[RATE_W:0];
            quo_in = {quo_ff[RATE_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[RATE_W-2:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff) else $error("divider restarted while running");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("done without a run");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> ({33'd0, rem_ff} < dvs_ff || rem_ff <= {1'b0, NS_PER_SEC}))
      else $error("remainder out of range");
endmodule

// ----- src/udp_flow_stats_table_top.sv -----
// udp flow statistics table: frame checks, flow lookup, counters and rate
//
//  channel  | ports                  | handshake
//  request  | req_*, start, busy     | taken when start && !busy
//  result   | rsp_*, rsp_valid       | one-cycle strobe, cannot be stalled
//  config   | csr_*                  | csr_valid && csr_ready, ready always high
//
// one request at a time. a frame that fails the checks shows its result in the
// cycle right after acceptance. a qualified frame scans the occupied slots one
// per cycle: a miss answers once every occupied slot has been compared, a hit
// goes on to update the slot's statistics, and a hit with a refreshed rate also
// waits for the bit-serial divider. busy drops with the result. the key and
// statistics memories each have one read and one write port. reset empties the
// table at once (fill count). results are never held off.
`timescale 1ns / 1ps
module udp_flow_stats_table_top (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_ether_type,
   input  logic [3:0] req_header_words,
   input  logic [7:0] req_ip_protocol,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_ip_total_length,
   input  logic [63:0] req_now_ns,
   output logic rsp_valid,
   output logic rsp_qualified,
   output logic rsp_recorded,
   output logic rsp_new_flow,
   output logic rsp_table_full,
   output logic [63:0] rsp_flow_packets,
   output logic [63:0] rsp_flow_bytes,
   output logic [ufst_pkg::RATE_W-1:0] rsp_flow_rate,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [31:0] csr_local_address
);
   import ufst_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_STAT = 2'd2;
   localparam logic [1:0] ST_DIV = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [31:0] local_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [15:0] len_ff, len_in;
   logic [63:0] now_ff, now_in;
   stat_type upd_ff, upd_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_qual_ff, rsp_qual_in;
   logic rsp_rec_ff, rsp_rec_in;
   logic rsp_new_ff, rsp_new_in;
   logic rsp_full_ff, rsp_full_in;
   logic [63:0] rsp_pk_ff, rsp_pk_in;
   logic [63:0] rsp_by_ff, rsp_by_in;
   logic [RATE_W-1:0] rsp_rate_ff, rsp_rate_in;

   logic key_we;
   logic [IDX_W-1:0] key_waddr;
   logic [KEY_W-1:0] key_rdata;
   logic stat_we;
   logic [IDX_W-1:0] stat_waddr;
   stat_type stat_wdata, stat_rdata;

   logic div_start, div_done;
   logic [63:0] interval;
   logic [RATE_W-1:0] div_quo;
   logic frame_ok;
   logic [16:0] min_len;
   logic [63:0] pk_next;

   ufst_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_SLOTS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_ff),
      .rd_addr(scan_ff[IDX_W-1:0]), .rd_data(key_rdata)
   );

   ufst_ram #(.WIDTH(STAT_W), .DEPTH(FLOW_SLOTS)) u_stat_ram (
      .clock(clock), .wr_en(stat_we), .wr_addr(stat_waddr), .wr_data(stat_wdata),
      .rd_addr(cmp_idx_ff), .rd_data(stat_rdata)
   );

   ufst_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .divisor(interval),
      .done(div_done), .quotient(div_quo)
   );

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign min_len = 17'd22 + {11'd0, req_header_words, 2'b00};
   assign frame_ok = ({1'b0, req_frame_length} >= min_len)
                  && (req_frame_length >= 16'd34)
                  && (req_ether_type == ETYPE_IPV4)
                  && (req_dest_address == local_ff)
                  && (req_ip_protocol == PROTO_UDP);

   assign pk_next = stat_rdata.packets + 64'd1;
   assign interval = now_ff - stat_rdata.last_time;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      hit_idx_in = hit_idx_ff;
      key_in = key_ff;
      len_in = len_ff;
      now_in = now_ff;
      upd_in = upd_ff;
      rsp_valid_in = 1'b0;
      rsp_qual_in = rsp_qual_ff;
      rsp_rec_in = rsp_rec_ff;
      rsp_new_in = rsp_new_ff;
      rsp_full_in = rsp_full_ff;
      rsp_pk_in = rsp_pk_ff;
      rsp_by_in = rsp_by_ff;
      rsp_rate_in = rsp_rate_ff;
      key_we = 1'b0;
      key_waddr = count_ff[IDX_W-1:0];
      stat_we = 1'b0;
      stat_waddr = count_ff[IDX_W-1:0];
      stat_wdata = upd_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = {req_source_address, req_dest_address,
                         req_source_port, req_dest_port};
               len_in = req_ip_total_length;
               now_in = req_now_ns;
               scan_in = '0;
               if (frame_ok) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_qual_in = 1'b0;
                  rsp_rec_in = 1'b0;
                  rsp_new_in = 1'b0;
                  rsp_full_in = 1'b0;
                  rsp_pk_in = '0;
                  rsp_by_in = '0;
                  rsp_rate_in = '0;
               end
            end
         end
         ST_SCAN: begin
            // read slot scan_ff while comparing the slot read in the previous cycle
            if (cmp_vld_ff && key_rdata == key_ff) begin
               hit_idx_in = cmp_idx_ff;
               state_in = ST_STAT;
            end else if (scan_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_qual_in = 1'b1;
               rsp_rate_in = '0;
               state_in = ST_IDLE;
               if (count_ff == CNT_W'(FLOW_SLOTS)) begin
                  rsp_rec_in = 1'b0;
                  rsp_new_in = 1'b0;
                  rsp_full_in = 1'b1;
                  rsp_pk_in = '0;
                  rsp_by_in = '0;
               end else begin
                  key_we = 1'b1;
                  stat_we = 1'b1;
                  stat_wdata.packets = 64'd1;
                  stat_wdata.bytes = {48'd0, len_ff};
                  stat_wdata.last_time = now_ff;
                  stat_wdata.rate = '0;
                  count_in = count_ff + 1'b1;
                  rsp_rec_in = 1'b1;
                  rsp_new_in = 1'b1;
                  rsp_full_in = 1'b0;
                  rsp_pk_in = 64'd1;
                  rsp_by_in = {48'd0, len_ff};
               end
            end
         end
         ST_STAT: begin
            upd_in.packets = pk_next;
            upd_in.bytes = stat_rdata.bytes + {48'd0, len_ff};
            upd_in.last_time = stat_rdata.last_time;
            upd_in.rate = stat_rdata.rate;
            // a count that wrapped to 0 or 1 leaves time and rate alone
            if (pk_next > 64'd1) begin
               upd_in.last_time = now_ff;
            end
            if (pk_next > 64'd1 && interval != 64'd0) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               stat_we = 1'b1;
               stat_waddr = hit_idx_ff;
               stat_wdata = upd_in;
               rsp_valid_in = 1'b1;
               rsp_qual_in = 1'b1;
               rsp_rec_in = 1'b1;
               rsp_new_in = 1'b0;
               rsp_full_in = 1'b0;
               rsp_pk_in = upd_in.packets;
               rsp_by_in = upd_in.bytes;
               rsp_rate_in = upd_in.rate;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               stat_we = 1'b1;
               stat_waddr = hit_idx_ff;
               stat_wdata.rate = div_quo;
               rsp_valid_in = 1'b1;
               rsp_qual_in = 1'b1;
               rsp_rec_in = 1'b1;
               rsp_new_in = 1'b0;
               rsp_full_in = 1'b0;
               rsp_pk_in = upd_ff.packets;
               rsp_by_in = upd_ff.bytes;
               rsp_rate_in = div_quo;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         local_ff <= LOCAL_ADDRESS_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            local_ff <= csr_local_address;
         end
      end
      scan_ff <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_idx_ff <= hit_idx_in;
      key_ff <= key_in;
      len_ff <= len_in;
      now_ff <= now_in;
      upd_ff <= upd_in;
      rsp_qual_ff <= rsp_qual_in;
      rsp_rec_ff <= rsp_rec_in;
      rsp_new_ff <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
      rsp_pk_ff <= rsp_pk_in;
      rsp_by_ff <= rsp_by_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_qualified = rsp_qual_ff;
   assign rsp_recorded = rsp_rec_ff;
   assign rsp_new_flow = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_flow_packets = rsp_pk_ff;
   assign rsp_flow_bytes = rsp_by_ff;
   assign rsp_flow_rate = rsp_rate_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FLOW_SLOTS)) else $error("fill count past table size");
   a_full_not_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_qualified && !rsp_recorded)
      else $error("dropped flow marked recorded");
   a_new_one_pkt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_flow |-> rsp_flow_packets == 64'd1 && rsp_flow_rate == '0)
      else $error("new flow with stale counts");
   a_div_from_stat: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIV) else $error("divider started off path");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      key_we |=> count_ff == $past(count_ff) + 1'b1) else $error("insert lost");
endmodule
